// ----- rtl/ops_pkg.sv -----
// ----------------------------------------------------------------------------
// ops_pkg
// Shared types, constants and register codes of the ook pulse slicer.
// ----------------------------------------------------------------------------
package ops_pkg;

	// default geometry of the majority filter and signal strength delay line
	localparam int WINDOW_LEN_DEF = 11;
	localparam int DELAY_LEN_DEF  = 14;

	// command queue between classifier and record builder
	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	// saturation limits
	localparam logic [15:0] TICK_MAX = 16'hFFFF;
	localparam logic [15:0] DUR_MAX  = 16'hFFFF;
	localparam logic [15:0] FLUSH_TAIL_US = 16'd1;

	// peak threshold emulation
	localparam logic [7:0] THD_RESET    = 8'd100;
	localparam logic [7:0] THD_MARGIN   = 8'd12;
	localparam logic [7:0] STRONG_LIMIT = 8'd200;
	localparam logic [7:0] OUTLIER_THD  = 8'd188;

	// register reset values
	localparam logic [7:0]  FIXED_THD_RST   = 8'd60;
	localparam logic [15:0] FLUSH_TICKS_RST = 16'd200;
	localparam logic [7:0]  PERIOD_US_RST   = 8'd25;

	// configuration port geometry
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIXED_THRESHOLD  = 2'd0,
		REG_FLUSH_TICKS      = 2'd1,
		REG_SAMPLE_PERIOD_US = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  fixed_threshold;
		logic [15:0] flush_ticks;
		logic [7:0]  sample_period_us;
	} cfg_t;

	// one classified event, expanded by the back end into one or two records
	typedef struct packed {
		logic        flush;
		logic [15:0] ticks;
		logic        level;
		logic [7:0]  rssi;
		logic [7:0]  thd;
	} cmd_t;

endpackage

// ----- rtl/ops_sample_if.sv -----
// ----------------------------------------------------------------------------
// ops_sample_if
// Sample channel: one raw data bit and one signal strength byte per transaction.
// ----------------------------------------------------------------------------
interface ops_sample_if;
	logic       valid;
	logic       ready;
	logic       data_bit;
	logic [7:0] signal_strength;

	modport source (output valid, output data_bit, output signal_strength, input ready);
	modport sink   (input valid, input data_bit, input signal_strength, output ready);
endinterface

// ----- rtl/ops_record_if.sv -----
// ----------------------------------------------------------------------------
// ops_record_if
// Pulse record channel: one pulse record per transaction.
// ----------------------------------------------------------------------------
interface ops_record_if;
	logic        valid;
	logic        ready;
	logic [15:0] duration_us;
	logic        level;
	logic [7:0]  pulse_rssi;
	logic        is_flush;
	logic [7:0]  peak_threshold;
	logic        last;

	modport source (output valid, output duration_us, output level, output pulse_rssi,
		output is_flush, output peak_threshold, output last, input ready);
	modport sink   (input valid, input duration_us, input level, input pulse_rssi,
		input is_flush, input peak_threshold, input last, output ready);
endinterface

// ----- rtl/ops_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ops_cfg_if
// Configuration write channel: register index and write data per transaction.
// ----------------------------------------------------------------------------
interface ops_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ops_pkg::CFG_IDX_W-1:0]    index;
	logic [ops_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ops_front.sv -----
// ----------------------------------------------------------------------------
// ops_front
// Sample classifier: majority filter, edge and quiet-period detection,
// signal strength delay line and peak threshold emulation.
// ----------------------------------------------------------------------------
module ops_front #(
	parameter int WINDOW_LEN = ops_pkg::WINDOW_LEN_DEF,
	parameter int DELAY_LEN  = ops_pkg::DELAY_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ops_sample_if.sink    samples,
	input  ops_pkg::cfg_t cfg,
	output logic          push_valid,
	input  logic          push_ready,
	output ops_pkg::cmd_t push_cmd
);

	localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
	localparam int HALF    = WINDOW_LEN / 2;
	localparam int DLY_OFF = (HALF + 2) % DELAY_LEN;
	localparam int DAW     = $clog2(DELAY_LEN);

	logic [WINDOW_LEN-1:0] window_q;
	logic                  level_q;
	logic [15:0]           ticks_q;
	logic [7:0]            dly_q [DELAY_LEN];
	logic [DAW-1:0]        wr_idx_q;
	logic [7:0]            steady_q;
	logic [7:0]            thd_q;
	logic [2:0]            phase_q;

	logic [WINDOW_LEN-1:0] window_n;
	logic [CNT_W-1:0]      count_n;
	logic                  now_level;
	logic [DAW-1:0]        rd_idx;
	logic [DAW-1:0]        wr_idx_n;
	logic [7:0]            delayed;
	logic [15:0]           ticks_inc;
	logic                  stepped;
	logic                  is_edge;
	logic                  is_flush;
	logic                  accept;
	logic [2:0]            phase_n;
	logic [7:0]            thd_dec;
	logic [7:0]            thd_n;

	assign samples.ready = push_ready;
	assign accept        = samples.valid && push_ready;

	// majority filter over the shifted window
	always_comb begin
		window_n = {window_q[WINDOW_LEN-2:0], samples.data_bit};
		count_n  = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			count_n = count_n + CNT_W'(window_n[i]);
		end
		now_level = (count_n > CNT_W'(HALF));
	end

	// delay line read position, a fixed number of samples behind the write
	always_comb begin
		if (wr_idx_q >= DAW'(DLY_OFF)) begin
			rd_idx = wr_idx_q - DAW'(DLY_OFF);
		end else begin
			rd_idx = wr_idx_q + DAW'(DELAY_LEN - DLY_OFF);
		end
		wr_idx_n = (wr_idx_q == DAW'(DELAY_LEN - 1)) ? '0 : wr_idx_q + 1'b1;
		delayed  = dly_q[rd_idx];
	end

	// edge and quiet-period classification
	always_comb begin
		stepped   = (ticks_q != ops_pkg::TICK_MAX);
		ticks_inc = stepped ? ticks_q + 16'd1 : ticks_q;
		is_edge   = (now_level != level_q);
		is_flush  = !is_edge && stepped && (ticks_inc == cfg.flush_ticks);

		push_valid     = accept && (is_edge || is_flush);
		push_cmd.flush = is_flush;
		push_cmd.ticks = ticks_inc;
		push_cmd.level = level_q;
		push_cmd.rssi  = is_edge ? steady_q : 8'd0;
		push_cmd.thd   = thd_q;
	end

	// peak threshold: slow decay toward the floor, jump below strong signals
	always_comb begin
		phase_n = phase_q + 3'd1;
		if (phase_n == 3'd0 && thd_q > cfg.fixed_threshold) begin
			thd_dec = thd_q - 8'd1;
		end else begin
			thd_dec = thd_q;
		end
		thd_n = thd_dec;
		if ({1'b0, samples.signal_strength} > ({1'b0, thd_dec} + {1'b0, ops_pkg::THD_MARGIN}))
		begin
			if (samples.signal_strength > ops_pkg::STRONG_LIMIT) begin
				thd_n = ops_pkg::OUTLIER_THD;
			end else begin
				thd_n = samples.signal_strength - ops_pkg::THD_MARGIN;
			end
			if (thd_n < cfg.fixed_threshold) begin
				thd_n = cfg.fixed_threshold;
			end
		end
	end

	// state update per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			level_q  <= 1'b0;
			ticks_q  <= '0;
			for (int i = 0; i < DELAY_LEN; i++) begin
				dly_q[i] <= '0;
			end
			wr_idx_q <= '0;
			steady_q <= '0;
			thd_q    <= ops_pkg::THD_RESET;
			phase_q  <= '0;
		end else if (accept) begin
			window_q        <= window_n;
			level_q         <= now_level;
			ticks_q         <= is_edge ? 16'd0 : ticks_inc;
			dly_q[wr_idx_q] <= samples.signal_strength;
			wr_idx_q        <= wr_idx_n;
			steady_q        <= delayed;
			thd_q           <= thd_n;
			phase_q         <= phase_n;
		end
	end

`ifndef SYNTHESIS
	a_edge_clears_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_edge) |=> (ticks_q == 16'd0))
		else $error("tick counter not cleared after an edge");
`endif

endmodule

// ----- rtl/ops_queue.sv -----
// ----------------------------------------------------------------------------
// ops_queue
// Short command queue between the classifier and the record builder.
// ----------------------------------------------------------------------------
module ops_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ops_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ops_pkg::cmd_t head
);

	ops_pkg::cmd_t                 mem_q [ops_pkg::QDEPTH];
	logic [ops_pkg::QAW-1:0]       wr_ptr_q;
	logic [ops_pkg::QAW-1:0]       rd_ptr_q;
	logic [ops_pkg::QCW-1:0]       count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = (count_q != ops_pkg::QCW'(ops_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == ops_pkg::QAW'(ops_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ops_pkg::QAW'(ops_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ops_pkg::QCW'(ops_pkg::QDEPTH))
		else $error("command queue overfilled");
`endif

endmodule

// ----- rtl/ops_back.sv -----
// ----------------------------------------------------------------------------
// ops_back
// Record builder: scales tick counts to saturated microseconds and expands
// each command into its pulse records behind an output register.
// ----------------------------------------------------------------------------
module ops_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ops_pkg::cfg_t cfg,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  ops_pkg::cmd_t head,
	ops_record_if.source  records
);

	logic        out_valid_q;
	logic        second_q;
	logic [15:0] dur_q;
	logic        level_q;
	logic [7:0]  rssi_q;
	logic        flush_q;
	logic [7:0]  thd_q;
	logic        last_q;

	logic        advance;
	logic        emit;
	logic [23:0] product;
	logic [15:0] dur_sat;

	assign advance   = !out_valid_q || records.ready;
	assign emit      = advance && pop_valid;
	assign pop_ready = advance && (!head.flush || second_q);

	// duration scaling with saturation
	always_comb begin
		product = {8'd0, head.ticks} * {16'd0, cfg.sample_period_us};
		dur_sat = (product > {8'd0, ops_pkg::DUR_MAX}) ? ops_pkg::DUR_MAX : product[15:0];
	end

	// output register and flush pair sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			second_q    <= head.flush && !second_q;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// record payload
	always_ff @(posedge clk) begin
		if (emit) begin
			thd_q <= head.thd;
			priority if (head.flush && second_q) begin
				dur_q   <= ops_pkg::FLUSH_TAIL_US;
				level_q <= !head.level;
				rssi_q  <= 8'd0;
				flush_q <= 1'b1;
				last_q  <= 1'b1;
			end else if (head.flush) begin
				dur_q   <= dur_sat;
				level_q <= head.level;
				rssi_q  <= 8'd0;
				flush_q <= 1'b1;
				last_q  <= 1'b0;
			end else begin
				dur_q   <= dur_sat;
				level_q <= head.level;
				rssi_q  <= head.rssi;
				flush_q <= 1'b0;
				last_q  <= 1'b1;
			end
		end
	end

	assign records.valid          = out_valid_q;
	assign records.duration_us    = dur_q;
	assign records.level          = level_q;
	assign records.pulse_rssi     = rssi_q;
	assign records.is_flush       = flush_q;
	assign records.peak_threshold = thd_q;
	assign records.last           = last_q;

`ifndef SYNTHESIS
	a_second_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (pop_valid && head.flush))
		else $error("flush tail pending without its command");
	a_not_last_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (second_q && flush_q))
		else $error("non-final record without a pending flush tail");
`endif

endmodule

// ----- rtl/ook_pulse_slicer.sv -----
// ----------------------------------------------------------------------------
// ook_pulse_slicer
// On-off-keyed pulse slicer: majority-filtered edge timing with flush pairs.
// ----------------------------------------------------------------------------
// The block takes one sample transaction per clock cycle as long as its
// two-entry command queue has room. A sample that changes the filtered level
// yields one pulse record; a sample that completes the quiet period yields a
// flush pair of two records. The record builder sends one record per cycle
// while the record channel is ready; the first record of a sample passes the
// queue entry, then the output register, before it is presented on the record
// channel. Input stalls only while the queue is full, which happens when the
// output side is held back or a flush pair is followed at once by further
// records.
// Configuration writes are taken in any cycle; register them while idle.
// ----------------------------------------------------------------------------
module ook_pulse_slicer #(
	parameter int WINDOW_LEN = ops_pkg::WINDOW_LEN_DEF,
	parameter int DELAY_LEN  = ops_pkg::DELAY_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ops_sample_if.sink   samples,
	ops_record_if.source records,
	ops_cfg_if.sink      cfg
);

	ops_pkg::cfg_t cfg_q;
	logic          push_valid;
	logic          push_ready;
	ops_pkg::cmd_t push_cmd;
	logic          pop_valid;
	logic          pop_ready;
	ops_pkg::cmd_t head;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fixed_threshold  <= ops_pkg::FIXED_THD_RST;
			cfg_q.flush_ticks      <= ops_pkg::FLUSH_TICKS_RST;
			cfg_q.sample_period_us <= ops_pkg::PERIOD_US_RST;
		end else if (cfg.valid) begin
			unique case (ops_pkg::reg_idx_t'(cfg.index))
				ops_pkg::REG_FIXED_THRESHOLD: begin
					cfg_q.fixed_threshold <= cfg.data[7:0];
				end
				ops_pkg::REG_FLUSH_TICKS: begin
					cfg_q.flush_ticks <= cfg.data[15:0];
				end
				ops_pkg::REG_SAMPLE_PERIOD_US: begin
					cfg_q.sample_period_us <= cfg.data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// classifier
	ops_front #(
		.WINDOW_LEN (WINDOW_LEN),
		.DELAY_LEN  (DELAY_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// command queue
	ops_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.head       (head)
	);

	// record builder
	ops_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.head      (head),
		.records   (records)
	);

endmodule

// ----- verif/tb_ook_pulse_slicer.sv -----
// ----------------------------------------------------------------------------
// tb_ook_pulse_slicer
// Self-checking bench for the ook pulse slicer.
// ----------------------------------------------------------------------------
// Sample transactions are queued by the stimulus process and sent by a clocked
// driver with random gaps. Each accepted sample is run through a local model
// of the majority filter, edge timer, flush logic and peak threshold, and the
// pulse records it should cause are queued. A clocked monitor with random
// back-pressure checks every record field by field against that queue.
// Register settings change between phases, once all records have drained.
// ----------------------------------------------------------------------------
module tb_ook_pulse_slicer;

	localparam int WIN          = ops_pkg::WINDOW_LEN_DEF;
	localparam int DLY          = ops_pkg::DELAY_LEN_DEF;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic       data_bit;
		logic [7:0] strength;
	} sample_t;

	typedef struct packed {
		logic [15:0] duration_us;
		logic        level;
		logic [7:0]  pulse_rssi;
		logic        is_flush;
		logic [7:0]  peak_threshold;
		logic        last;
	} pulse_rec_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ops_sample_if smp ();
	ops_record_if rec ();
	ops_cfg_if    cfg_bus ();

	ook_pulse_slicer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.records (rec),
		.cfg     (cfg_bus)
	);

	// clock
	always #5 clk = ~clk;

	// stimulus and expected record stores
	sample_t    pending_samples[$];
	pulse_rec_t expected_pulses[$];

	// register copies
	logic [7:0]  fixed_thd = ops_pkg::FIXED_THD_RST;
	logic [15:0] flush_len = ops_pkg::FLUSH_TICKS_RST;
	logic [7:0]  period_us = ops_pkg::PERIOD_US_RST;

	// slicer state copies
	logic [WIN-1:0] window_bits = '0;
	logic           held_level  = 1'b0;
	logic [15:0]    quiet_ticks = '0;
	logic [7:0]     rssi_hist[DLY] = '{default: 8'd0};
	int             hist_wr     = 0;
	logic [7:0]     lagged_rssi = '0;
	logic [7:0]     peak_thd    = ops_pkg::THD_RESET;
	logic [2:0]     decay_cnt   = '0;

	// idling and bookkeeping
	int idle_pct  = 23;
	int stall_pct = 23;
	int fails     = 0;
	int n_samples = 0;
	int n_records = 0;
	int n_flush   = 0;
	int n_writes  = 0;
	int n_phases  = 0;
	int quiet_cycles = 0;

	// ticks to microseconds, saturating
	function automatic logic [15:0] to_us(input logic [15:0] ticks);
		int unsigned prod;
		prod = ticks * period_us;
		return (prod > ops_pkg::DUR_MAX) ? ops_pkg::DUR_MAX : prod[15:0];
	endfunction

	// advance the slicer by one sample and queue the records it causes
	task automatic slice_sample(input sample_t s);
		logic       now_level;
		logic [7:0] delayed;
		logic [15:0] prev_ticks;
		logic [7:0] thd_seen;
		int         hist_rd;
		window_bits = {window_bits[WIN-2:0], s.data_bit};
		now_level = ($countones(window_bits) > WIN / 2);

		hist_rd = (hist_wr + DLY - (WIN / 2 + 2)) % DLY;
		delayed = rssi_hist[hist_rd];
		rssi_hist[hist_wr] = s.strength;
		hist_wr = (hist_wr + 1) % DLY;

		prev_ticks = quiet_ticks;
		if (quiet_ticks != ops_pkg::TICK_MAX) quiet_ticks = quiet_ticks + 16'd1;
		thd_seen = peak_thd;

		// edge record, or flush pair once the quiet period is reached
		if (now_level != held_level) begin
			expected_pulses.push_back(pulse_rec_t'{to_us(quiet_ticks), held_level,
				lagged_rssi, 1'b0, thd_seen, 1'b1});
			held_level  = now_level;
			quiet_ticks = '0;
		end else if (quiet_ticks != prev_ticks && quiet_ticks == flush_len) begin
			expected_pulses.push_back(pulse_rec_t'{to_us(quiet_ticks), held_level,
				8'd0, 1'b1, thd_seen, 1'b0});
			expected_pulses.push_back(pulse_rec_t'{ops_pkg::FLUSH_TAIL_US, ~held_level,
				8'd0, 1'b1, thd_seen, 1'b1});
		end
		lagged_rssi = delayed;

		// peak threshold: slow decay toward the floor, jump under strong signal
		decay_cnt = decay_cnt + 3'd1;
		if (decay_cnt == 3'd0 && peak_thd > fixed_thd) peak_thd = peak_thd - 8'd1;
		if (int'(s.strength) > int'(peak_thd) + int'(ops_pkg::THD_MARGIN)) begin
			peak_thd = s.strength - ops_pkg::THD_MARGIN;
			if (s.strength > ops_pkg::STRONG_LIMIT) peak_thd = ops_pkg::OUTLIER_THD;
			if (peak_thd < fixed_thd) peak_thd = fixed_thd;
		end
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid           <= 1'b0;
			smp.data_bit        <= 1'b0;
			smp.signal_strength <= 8'd0;
		end else if (!smp.valid || smp.ready) begin
			if (smp.valid) begin
				slice_sample(sample_t'{smp.data_bit, smp.signal_strength});
				n_samples++;
			end
			if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				smp.valid           <= 1'b1;
				smp.data_bit        <= pending_samples[0].data_bit;
				smp.signal_strength <= pending_samples[0].strength;
				void'(pending_samples.pop_front());
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// record monitor
	always @(posedge clk or negedge arst_n) begin
		pulse_rec_t want;
		if (!arst_n) begin
			rec.ready <= 1'b0;
		end else begin
			if (rec.valid && rec.ready) begin
				n_records++;
				if (rec.is_flush === 1'b1) n_flush++;
				if (expected_pulses.size() == 0) begin
					$error("record transaction with none expected: duration_us %0d level %0d",
						rec.duration_us, rec.level);
					fails++;
				end else begin
					want = expected_pulses.pop_front();
					check_field("duration_us", want.duration_us, rec.duration_us);
					check_field("level", want.level, rec.level);
					check_field("pulse_rssi", want.pulse_rssi, rec.pulse_rssi);
					check_field("is_flush", want.is_flush, rec.is_flush);
					check_field("peak_threshold", want.peak_threshold, rec.peak_threshold);
					check_field("last", want.last, rec.last);
				end
			end
			rec.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (smp.valid && smp.ready) || (rec.valid && rec.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ook_pulse_slicer test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one register write, model copy updated on the transaction
	task automatic write_reg(input ops_pkg::reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			ops_pkg::REG_FIXED_THRESHOLD:  fixed_thd = val[7:0];
			ops_pkg::REG_FLUSH_TICKS:      flush_len = val;
			ops_pkg::REG_SAMPLE_PERIOD_US: period_us = val[7:0];
			default: ;
		endcase
		n_writes++;
		cfg_bus.valid <= 1'b0;
	endtask

	// wait until every sample is taken and every record has come back
	task automatic settle();
		while (pending_samples.size() != 0 || smp.valid || expected_pulses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		n_phases++;
	endtask

	function automatic logic [7:0] pick_strength();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 59));
			1: return 8'($urandom_range(60, 200));
			2: return 8'($urandom_range(201, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	// pulse trains: runs of one level with occasional noise bits
	task automatic queue_bursts(input int count);
		logic lvl;
		int   run;
		lvl = 1'($urandom_range(0, 1));
		while (count > 0) begin
			case ($urandom_range(0, 19))
				0:             run = $urandom_range(40, 90);
				1, 2, 3, 4, 5: run = $urandom_range(12, 40);
				default:       run = $urandom_range(1, 12);
			endcase
			repeat (run) begin
				pending_samples.push_back(sample_t'{
					($urandom_range(0, 99) < 8) ? ~lvl : lvl, pick_strength()});
				count--;
			end
			lvl = ~lvl;
		end
	endtask

	initial begin
		logic lvl;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = ops_pkg::REG_FIXED_THRESHOLD;
		cfg_bus.data        = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: edges with strongest, outlier and weakest signal
		repeat (6) pending_samples.push_back(sample_t'{1'b1, 8'd255});
		pending_samples.push_back(sample_t'{1'b1, 8'd201});
		pending_samples.push_back(sample_t'{1'b1, 8'd200});
		repeat (6) pending_samples.push_back(sample_t'{1'b0, 8'd0});
		pending_samples.push_back(sample_t'{1'b0, 8'd7});
		settle();

		// highest floor, shortest quiet period, longest tick
		write_reg(ops_pkg::REG_FIXED_THRESHOLD, 16'hA5FF);
		write_reg(ops_pkg::REG_FLUSH_TICKS, 16'd1);
		write_reg(ops_pkg::REG_SAMPLE_PERIOD_US, 16'h5AFF);
		lvl = ~held_level;
		repeat (8) pending_samples.push_back(sample_t'{lvl, 8'hC3});
		pending_samples.push_back(sample_t'{lvl, 8'h3C});
		settle();

		// all-zero settings: no flush at all, zero durations
		write_reg(ops_pkg::REG_FIXED_THRESHOLD, 16'hFF00);
		write_reg(ops_pkg::REG_FLUSH_TICKS, 16'd0);
		write_reg(ops_pkg::REG_SAMPLE_PERIOD_US, 16'h0000);
		queue_bursts(60);
		settle();

		// long quiet period: capped flush duration, a single flush, then a capped edge
		idle_pct  = 0;
		stall_pct = 0;
		write_reg(ops_pkg::REG_FLUSH_TICKS, 16'd260);
		write_reg(ops_pkg::REG_SAMPLE_PERIOD_US, 16'd255);
		lvl = ~held_level;
		repeat (272) pending_samples.push_back(sample_t'{lvl, pick_strength()});
		repeat (12) pending_samples.push_back(sample_t'{~lvl, pick_strength()});
		settle();

		// random settings with pulse trains; one phase without idling
		for (int p = 0; p < 5; p++) begin
			idle_pct  = (p == 2) ? 0 : 23;
			stall_pct = (p == 2) ? 0 : 23;
			write_reg(ops_pkg::REG_FIXED_THRESHOLD, {8'($urandom), 8'($urandom)});
			write_reg(ops_pkg::REG_FLUSH_TICKS, (p == 4) ? ops_pkg::FLUSH_TICKS_RST
				: 16'($urandom_range(1, 48)));
			write_reg(ops_pkg::REG_SAMPLE_PERIOD_US, {8'($urandom),
				(p == 0) ? 8'd1 : 8'($urandom_range(1, 255))});
			queue_bursts(50);
			settle();
		end

		$display("run covered %0d samples in %0d phases with %0d register writes",
			n_samples, n_phases, n_writes);
		$display("%0d pulse records checked, %0d of them in flush pairs", n_records, n_flush);
		if (fails == 0) begin
			$display("ook_pulse_slicer test passed");
		end else begin
			$display("ook_pulse_slicer test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ops_pkg.sv
rtl/ops_sample_if.sv
rtl/ops_record_if.sv
rtl/ops_cfg_if.sv
rtl/ops_front.sv
rtl/ops_queue.sv
rtl/ops_back.sv
rtl/ook_pulse_slicer.sv
verif/tb_ook_pulse_slicer.sv
